>>> rtl/pefa_pkg.sv
// ----------------------------------------------------------------------------
// pefa_pkg
// Shared types and constants for the pen event frame assembler: event codes,
// register indexes, the configuration bundle and the frame snapshot word.
// ----------------------------------------------------------------------------
package pefa_pkg;

    localparam int unsigned RawW   = 32;
    localparam int unsigned ScrW   = 13;
    localparam int unsigned CoordW = 21;
    localparam int unsigned PresW  = 16;
    localparam int unsigned QuoW   = 21;
    localparam int unsigned ProdW  = RawW + QuoW;
    localparam int unsigned CntW   = 5;
    localparam int unsigned CfgIdxW = 3;

    // event classes and codes
    localparam logic [15:0] EV_SYN          = 16'd0;
    localparam logic [15:0] EV_KEY          = 16'd1;
    localparam logic [15:0] EV_ABS          = 16'd3;
    localparam logic [15:0] SYNC_FRAME      = 16'd0;
    localparam logic [15:0] ABS_X           = 16'd0;
    localparam logic [15:0] ABS_Y           = 16'd1;
    localparam logic [15:0] ABS_PRES        = 16'd24;
    localparam logic [15:0] KEY_TIP         = 16'd330;
    localparam logic [15:0] KEY_ERASER      = 16'd321;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_X_MIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_X_MAX  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_Y_MIN  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_Y_MAX  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_P_MIN  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_P_MAX  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd7;

    // axis being scaled
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_P = 2'd2;

    localparam logic [QuoW-1:0] PRES_SCALE = QuoW'(65535);

    typedef struct packed {
        logic signed [RawW-1:0] x_min;
        logic signed [RawW-1:0] x_max;
        logic signed [RawW-1:0] y_min;
        logic signed [RawW-1:0] y_max;
        logic signed [RawW-1:0] p_min;
        logic signed [RawW-1:0] p_max;
        logic [ScrW-1:0]        width;
        logic [ScrW-1:0]        height;
    } cfg_t;

    typedef struct packed {
        logic signed [RawW-1:0] x;
        logic signed [RawW-1:0] y;
        logic signed [RawW-1:0] p;
        logic                   pen;
        logic                   eraser;
    } frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

>>> rtl/pefa_front.sv
// ----------------------------------------------------------------------------
// pefa_front
// Event front end: accepts event words, latches axis values and pen flags,
// and pushes a frame snapshot into the queue on each sync report.
// ----------------------------------------------------------------------------
module pefa_front
    import pefa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            event_type,
    input  logic [15:0]            event_code,
    input  logic signed [RawW-1:0] event_value,
    input  logic                   q_full,
    output logic                   q_push,
    output frame_t                 q_data
);

    logic signed [RawW-1:0] x_reg, x_next;
    logic signed [RawW-1:0] y_reg, y_next;
    logic signed [RawW-1:0] p_reg, p_next;
    logic                   pen_reg, pen_next;
    logic                   eraser_reg, eraser_next;
    logic                   rubber_reg, rubber_next;
    logic                   accept;
    logic                   pressed;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign pressed  = (event_value != '0);

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        pen_next    = pen_reg;
        eraser_next = eraser_reg;
        rubber_next = rubber_reg;
        q_push      = 1'b0;
        if (accept)
        begin
            unique case (event_type)
                EV_ABS:
                begin
                    if (event_code == ABS_X)
                        x_next = event_value;
                    else if (event_code == ABS_Y)
                        y_next = event_value;
                    else if (event_code == ABS_PRES)
                        p_next = event_value;
                end
                EV_KEY:
                begin
                    if (event_code == KEY_TIP)
                    begin
                        pen_next    = pressed && !rubber_reg;
                        eraser_next = pressed && rubber_reg;
                    end
                    else if (event_code == KEY_ERASER)
                    begin
                        rubber_next = pressed;
                        if (!pressed)
                            eraser_next = 1'b0;
                    end
                end
                EV_SYN:
                begin
                    q_push = (event_code == SYNC_FRAME);
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    assign q_data = '{x: x_reg, y: y_reg, p: p_reg, pen: pen_reg, eraser: eraser_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            p_reg      <= '0;
            pen_reg    <= 1'b0;
            eraser_reg <= 1'b0;
            rubber_reg <= 1'b0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            p_reg      <= p_next;
            pen_reg    <= pen_next;
            eraser_reg <= eraser_next;
            rubber_reg <= rubber_next;
        end
    end

endmodule

>>> rtl/pefa_queue.sv
// ----------------------------------------------------------------------------
// pefa_queue
// Two-entry frame queue between the event front end and the scaling back end.
// ----------------------------------------------------------------------------
module pefa_queue
    import pefa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output frame_t pop_data
);

    frame_t      mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/pefa_back.sv
// ----------------------------------------------------------------------------
// pefa_back
// Frame back end: clamps each axis, multiplies by its scale and divides by
// the span in a shared restoring divider, then presents the result word.
// ----------------------------------------------------------------------------
module pefa_back
    import pefa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    output logic               q_pop,
    input  frame_t             q_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CoordW-1:0]  screen_x,
    output logic [CoordW-1:0]  screen_y,
    output logic [PresW-1:0]   pressure_level,
    output logic               pen_touching,
    output logic               eraser_touching
);

    back_state_t          state_reg, state_next;
    frame_t               frame_reg, frame_next;
    logic [1:0]           ax_reg, ax_next;
    logic [RawW-1:0]      span_reg, span_next;
    logic [RawW-1:0]      n_reg, n_next;
    logic [QuoW-1:0]      scale_reg, scale_next;
    logic [RawW-1:0]      rem_reg, rem_next;
    logic [QuoW-1:0]      sh_reg, sh_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [CoordW-1:0]    xres_reg, xres_next;
    logic [CoordW-1:0]    yres_reg, yres_next;
    logic [PresW-1:0]     pres_reg, pres_next;

    logic                 ovalid_reg, ovalid_next;
    logic [CoordW-1:0]    ox_reg, ox_next;
    logic [CoordW-1:0]    oy_reg, oy_next;
    logic [PresW-1:0]     op_reg, op_next;
    logic                 open_reg, open_next;
    logic                 oeras_reg, oeras_next;

    logic signed [RawW-1:0] sel_lo;
    logic signed [RawW-1:0] sel_hi;
    logic signed [RawW-1:0] sel_raw;
    logic [QuoW-1:0]        sel_scale;
    logic [RawW:0]          diff_span;
    logic [RawW:0]          diff_raw;
    logic [RawW-1:0]        span_eff;
    logic [RawW-1:0]        n_clamp;
    logic [ProdW-1:0]       product;
    logic [RawW:0]          trial;
    logic                   ge;
    logic [RawW-1:0]        step_rem;
    logic [QuoW-1:0]        step_sh;

    always_comb
    begin
        case (ax_reg)
            AX_X:
            begin
                sel_lo    = cfg.x_min;
                sel_hi    = cfg.x_max;
                sel_raw   = frame_reg.x;
                sel_scale = {cfg.width, 8'd0};
            end
            AX_Y:
            begin
                sel_lo    = cfg.y_min;
                sel_hi    = cfg.y_max;
                sel_raw   = frame_reg.y;
                sel_scale = {cfg.height, 8'd0};
            end
            default:
            begin
                sel_lo    = cfg.p_min;
                sel_hi    = cfg.p_max;
                sel_raw   = frame_reg.p;
                sel_scale = PRES_SCALE;
            end
        endcase
    end

    assign diff_span = {sel_hi[RawW-1], sel_hi} - {sel_lo[RawW-1], sel_lo};
    assign diff_raw  = {sel_raw[RawW-1], sel_raw} - {sel_lo[RawW-1], sel_lo};
    assign span_eff  = (diff_span[RawW] || (diff_span == '0)) ? RawW'(1) : diff_span[RawW-1:0];
    assign n_clamp   = diff_raw[RawW] ? '0 :
                       ((diff_raw[RawW-1:0] > span_eff) ? span_eff : diff_raw[RawW-1:0]);

    assign product  = ProdW'(n_reg) * ProdW'(scale_reg);

    assign trial    = {rem_reg, sh_reg[QuoW-1]};
    assign ge       = (trial >= {1'b0, span_reg});
    assign step_rem = ge ? RawW'(trial - {1'b0, span_reg}) : trial[RawW-1:0];
    assign step_sh  = {sh_reg[QuoW-2:0], ge};

    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        ax_next     = ax_reg;
        span_next   = span_reg;
        n_next      = n_reg;
        scale_next  = scale_reg;
        rem_next    = rem_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        xres_next   = xres_reg;
        yres_next   = yres_reg;
        pres_next   = pres_reg;
        q_pop       = 1'b0;
        ovalid_next = ovalid_reg && out_stall;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        op_next     = op_reg;
        open_next   = open_reg;
        oeras_next  = oeras_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    frame_next = q_data;
                    ax_next    = AX_X;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                span_next  = span_eff;
                n_next     = n_clamp;
                scale_next = sel_scale;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                rem_next   = product[ProdW-1:QuoW];
                sh_next    = product[QuoW-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = step_rem;
                sh_next  = step_sh;
                cnt_next = cnt_reg + CntW'(1);
                if (cnt_reg == CntW'(QuoW - 1))
                begin
                    case (ax_reg)
                        AX_X:
                        begin
                            xres_next  = step_sh;
                            ax_next    = AX_Y;
                            state_next = ST_PREP;
                        end
                        AX_Y:
                        begin
                            yres_next  = step_sh;
                            ax_next    = AX_P;
                            state_next = ST_PREP;
                        end
                        default:
                        begin
                            pres_next  = step_sh[PresW-1:0];
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = xres_reg;
                    oy_next     = yres_reg;
                    op_next     = pres_reg;
                    open_next   = frame_reg.pen;
                    oeras_next  = frame_reg.eraser;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        span_reg  <= span_next;
        n_reg     <= n_next;
        scale_reg <= scale_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        xres_reg  <= xres_next;
        yres_reg  <= yres_next;
        pres_reg  <= pres_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        op_reg    <= op_next;
        open_reg  <= open_next;
        oeras_reg <= oeras_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ax_reg     <= AX_X;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ax_reg     <= ax_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid       = ovalid_reg;
    assign screen_x        = ox_reg;
    assign screen_y        = oy_reg;
    assign pressure_level  = op_reg;
    assign pen_touching    = open_reg;
    assign eraser_touching = oeras_reg;

endmodule

>>> rtl/pen_event_frame_assembler_core.sv
// ----------------------------------------------------------------------------
// pen_event_frame_assembler_core
// Pen digitizer event to screen frame assembler, top level.
// ----------------------------------------------------------------------------
// Axis and key event words are taken one per cycle while the queue is not
// full; a sync report queues a snapshot (two reports may wait). For each frame
// the back end fetches the snapshot, then for each of X, Y and pressure clamps,
// multiplies and runs 21 steps of the shared restoring divider, then loads the
// output register; it fetches no new frame before that. When the queue is full
// the input stalls. Configuration registers are read while each axis is scaled,
// so a write takes effect for the axes scaled after it.
// ----------------------------------------------------------------------------
module pen_event_frame_assembler_core
    import pefa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CfgIdxW-1:0]     cfg_index,
    input  logic [RawW-1:0]        cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [15:0]            event_type,
    input  logic [15:0]            event_code,
    input  logic signed [RawW-1:0] event_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CoordW-1:0]      screen_x,
    output logic [CoordW-1:0]      screen_y,
    output logic [PresW-1:0]       pressure_level,
    output logic                   pen_touching,
    output logic                   eraser_touching
);

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    frame_t q_wdata;
    frame_t q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min  <= RawW'(0);
            cfg_reg.x_max  <= RawW'(1);
            cfg_reg.y_min  <= RawW'(0);
            cfg_reg.y_max  <= RawW'(1);
            cfg_reg.p_min  <= RawW'(0);
            cfg_reg.p_max  <= RawW'(1);
            cfg_reg.width  <= '0;
            cfg_reg.height <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_X_MIN:  cfg_reg.x_min  <= cfg_data;
                REG_X_MAX:  cfg_reg.x_max  <= cfg_data;
                REG_Y_MIN:  cfg_reg.y_min  <= cfg_data;
                REG_Y_MAX:  cfg_reg.y_max  <= cfg_data;
                REG_P_MIN:  cfg_reg.p_min  <= cfg_data;
                REG_P_MAX:  cfg_reg.p_max  <= cfg_data;
                REG_WIDTH:  cfg_reg.width  <= cfg_data[ScrW-1:0];
                REG_HEIGHT: cfg_reg.height <= cfg_data[ScrW-1:0];
            endcase
        end
    end

    pefa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    pefa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rdata)
    );

    pefa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_data          (q_rdata),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .pressure_level  (pressure_level),
        .pen_touching    (pen_touching),
        .eraser_touching (eraser_touching)
    );

endmodule

>>> rtl/pefa_checker.sv
// ----------------------------------------------------------------------------
// pefa_checker
// Port-level checks for the pen event frame assembler, bound to the top level.
// ----------------------------------------------------------------------------
module pefa_checker
    import pefa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CoordW-1:0] screen_x,
    input logic [CoordW-1:0] screen_y,
    input logic [PresW-1:0]  pressure_level,
    input logic              pen_touching,
    input logic              eraser_touching
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y)
            && $stable(pressure_level))
        else $error("output word changed while stalled");

    a_tool_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pen_touching && eraser_touching))
        else $error("pen and eraser both touching");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pen_touching) && $stable(eraser_touching))
        else $error("tool flags changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind pen_event_frame_assembler_core pefa_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .screen_x        (screen_x),
    .screen_y        (screen_y),
    .pressure_level  (pressure_level),
    .pen_touching    (pen_touching),
    .eraser_touching (eraser_touching)
);

>>> dv/tb_pen_event_frame_assembler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pen_event_frame_assembler_core
// Self-checking bench for the pen event frame assembler. A directed table of
// event words covers ignored events, clamping and the touch/rubber flag rules
// at reset settings; random pen frames then run under several axis and screen
// settings. Every sync report is predicted here and compared with the frames
// that come out, with random gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tb_pen_event_frame_assembler_core
    import pefa_pkg::*;
();

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [PresW-1:0]  p;
        logic              pen;
        logic              er;
    } frame_exp_t;

    typedef struct {
        logic [15:0]     etype;
        logic [15:0]     ecode;
        logic [RawW-1:0] evalue;
        bit              typed;
        frame_exp_t      want;
    } stim_row_t;

    typedef enum {
        PROF_EXTREME,
        PROF_INVERTED,
        PROF_EQUAL,
        PROF_TABLET,
        PROF_RANDOM,
        PROF_NARROW,
        PROF_NEGATIVE
    } profile_t;

    localparam frame_exp_t NO_FRAME    = '0;
    localparam int         DRAIN_CYC   = 120;
    localparam int         HOLD_CYC    = 1200;
    localparam int         PHASES      = 10;
    localparam int         FRAMES_PER  = 20;
    localparam int         CALM_PHASE  = 4;
    localparam int         PRESS_PHASE = 8;
    localparam int         ROWS        = 25;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CfgIdxW-1:0]     cfg_index;
    logic [RawW-1:0]        cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            event_type;
    logic [15:0]            event_code;
    logic signed [RawW-1:0] event_value;
    logic                   out_valid;
    logic                   out_stall;
    logic [CoordW-1:0]      screen_x;
    logic [CoordW-1:0]      screen_y;
    logic [PresW-1:0]       pressure_level;
    logic                   pen_touching;
    logic                   eraser_touching;

    // predictor state
    logic [RawW-1:0] cfg_shadow [8];
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
    logic [RawW-1:0] raw_p;
    logic            pen_down;
    logic            eraser_down;
    logic            rubber_near;

    frame_exp_t pending_frames [$];
    int         mismatches = 0;
    int         frames_seen = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;

    profile_t plan [PHASES] = '{PROF_TABLET, PROF_EXTREME, PROF_INVERTED, PROF_EQUAL,
                                PROF_RANDOM, PROF_NARROW, PROF_NEGATIVE, PROF_RANDOM,
                                PROF_TABLET, PROF_RANDOM};

    stim_row_t directed_rows [ROWS] = '{
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd0, 1'b0, 1'b0}},
        '{16'd2, 16'd0, 32'd5, 1'b0, NO_FRAME},
        '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_FRAME},
        '{EV_SYN, 16'hFFFF, 32'd0, 1'b0, NO_FRAME},
        '{EV_SYN, 16'd1, 32'hFFFF_FFFF, 1'b0, NO_FRAME},
        '{EV_KEY, 16'hFFFF, 32'd1, 1'b0, NO_FRAME},
        '{EV_ABS, 16'hFFFF, 32'd7, 1'b0, NO_FRAME},
        '{EV_ABS, ABS_PRES, 32'd1, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd65535, 1'b0, 1'b0}},
        '{EV_ABS, ABS_PRES, 32'h8000_0000, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd0, 1'b0, 1'b0}},
        '{EV_ABS, ABS_PRES, 32'h7FFF_FFFF, 1'b0, NO_FRAME},
        '{EV_ABS, ABS_X, 32'h7FFF_FFFF, 1'b0, NO_FRAME},
        '{EV_ABS, ABS_Y, 32'h8000_0000, 1'b0, NO_FRAME},
        '{EV_KEY, KEY_TIP, 32'h8000_0000, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd65535, 1'b1, 1'b0}},
        '{EV_KEY, KEY_ERASER, 32'd1, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd65535, 1'b1, 1'b0}},
        '{EV_KEY, KEY_TIP, 32'd1, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd65535, 1'b0, 1'b1}},
        '{EV_KEY, KEY_ERASER, 32'd0, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b1, '{21'd0, 21'd0, 16'd65535, 1'b0, 1'b0}},
        '{EV_KEY, KEY_TIP, 32'hFFFF_FFFF, 1'b0, NO_FRAME},
        '{EV_KEY, KEY_ERASER, 32'd0, 1'b0, NO_FRAME},
        '{EV_SYN, SYNC_FRAME, 32'd0, 1'b0, NO_FRAME}
    };

    pen_event_frame_assembler_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .event_type      (event_type),
        .event_code      (event_code),
        .event_value     (event_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .pressure_level  (pressure_level),
        .pen_touching    (pen_touching),
        .eraser_touching (eraser_touching)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] scaled_axis(logic [RawW-1:0] raw, logic [RawW-1:0] lo_b,
                                               logic [RawW-1:0] hi_b, logic [63:0] scale);
        longint     lo;
        longint     hi;
        longint     r;
        longint     span;
        logic [63:0] n;
        logic [63:0] d;
        lo = $signed(lo_b);
        hi = $signed(hi_b);
        r = $signed(raw);
        span = hi - lo;
        if (span < 1)
            span = 1;
        if (r < lo)
            r = lo;
        if (r > lo + span)
            r = lo + span;
        n = r - lo;
        d = span;
        return (n * scale) / d;
    endfunction

    function automatic bit predict_event(logic [15:0] t, logic [15:0] c, logic [RawW-1:0] v,
                                         output frame_exp_t f);
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sp;
        bit          pressed;
        f = NO_FRAME;
        pressed = (v != '0);
        if (t == EV_ABS)
        begin
            if (c == ABS_X)
                raw_x = v;
            else if (c == ABS_Y)
                raw_y = v;
            else if (c == ABS_PRES)
                raw_p = v;
            return 1'b0;
        end
        if (t == EV_KEY)
        begin
            if (c == KEY_TIP)
            begin
                pen_down = pressed && !rubber_near;
                eraser_down = pressed && rubber_near;
            end
            else if (c == KEY_ERASER)
            begin
                rubber_near = pressed;
                if (!pressed)
                    eraser_down = 1'b0;
            end
            return 1'b0;
        end
        if (t == EV_SYN && c == SYNC_FRAME)
        begin
            sx = scaled_axis(raw_x, cfg_shadow[REG_X_MIN], cfg_shadow[REG_X_MAX],
                             64'(cfg_shadow[REG_WIDTH]) * 256);
            sy = scaled_axis(raw_y, cfg_shadow[REG_Y_MIN], cfg_shadow[REG_Y_MAX],
                             64'(cfg_shadow[REG_HEIGHT]) * 256);
            sp = scaled_axis(raw_p, cfg_shadow[REG_P_MIN], cfg_shadow[REG_P_MAX], 64'd65535);
            f.x = sx[CoordW-1:0];
            f.y = sy[CoordW-1:0];
            f.p = sp[PresW-1:0];
            f.pen = pen_down;
            f.er = eraser_down;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    function automatic int stall_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [RawW-1:0] pick_raw(int axis);
        logic [RawW-1:0] lo;
        logic [RawW-1:0] hi;
        longint          span;
        int              r;
        lo = cfg_shadow[2 * axis];
        hi = cfg_shadow[2 * axis + 1];
        r = $urandom_range(0, 9);
        case (r)
            0: return lo;
            1: return hi;
            2: return lo - 1;
            3: return hi + 1;
            4, 5: return $urandom;
            default:
            begin
                span = longint'($signed(hi)) - longint'($signed(lo));
                if (span < 1)
                    span = 1;
                return lo + RawW'(longint'($urandom) % (span + 1));
            end
        endcase
    endfunction

    function automatic logic [RawW-1:0] key_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return '0;
        if (r < 70)
            return 32'd1;
        return $urandom;
    endfunction

    // offer one word; return at the falling edge after it is taken
    task automatic send_word(logic [15:0] t, logic [15:0] c, logic [RawW-1:0] v,
                             bit typed, frame_exp_t typed_frame);
        int         gap;
        frame_exp_t f;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        event_type <= t;
        event_code <= c;
        event_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_event(t, c, v, f))
            pending_frames.push_back(typed ? typed_frame : f);
        @(negedge clk);
    endtask

    task automatic send_frame(bit axes_only);
        bit rubber_first;
        bit do_rubber;
        bit do_touch;
        int r;
        if (axes_only)
        begin
            send_word(EV_ABS, ABS_X, pick_raw(0), 1'b0, NO_FRAME);
            send_word(EV_SYN, SYNC_FRAME, $urandom, 1'b0, NO_FRAME);
            return;
        end
        rubber_first = $urandom_range(0, 1);
        do_rubber = $urandom_range(0, 99) < 20;
        do_touch = $urandom_range(0, 99) < 35;
        if (do_rubber && rubber_first)
            send_word(EV_KEY, KEY_ERASER, key_state(), 1'b0, NO_FRAME);
        if ($urandom_range(0, 99) < 70)
            send_word(EV_ABS, ABS_X, pick_raw(0), 1'b0, NO_FRAME);
        if ($urandom_range(0, 99) < 70)
            send_word(EV_ABS, ABS_Y, pick_raw(1), 1'b0, NO_FRAME);
        if ($urandom_range(0, 99) < 70)
            send_word(EV_ABS, ABS_PRES, pick_raw(2), 1'b0, NO_FRAME);
        if (do_touch)
            send_word(EV_KEY, KEY_TIP, key_state(), 1'b0, NO_FRAME);
        if (do_rubber && !rubber_first)
            send_word(EV_KEY, KEY_ERASER, key_state(), 1'b0, NO_FRAME);
        r = $urandom_range(0, 99);
        if (r < 88)
            send_word(EV_SYN, SYNC_FRAME, $urandom, 1'b0, NO_FRAME);
        else if (r < 94)
            send_word(EV_SYN, 16'($urandom_range(1, 65535)), $urandom, 1'b0, NO_FRAME);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_word(16'($urandom), 16'($urandom), $urandom, 1'b0, NO_FRAME);
            1: send_word(EV_ABS, 16'($urandom), $urandom, 1'b0, NO_FRAME);
            2: send_word(EV_KEY, 16'($urandom), $urandom, 1'b0, NO_FRAME);
            default: send_word(EV_SYN, 16'($urandom_range(1, 65535)), $urandom, 1'b0,
                               NO_FRAME);
        endcase
    endtask

    // drop valid, wait for every frame, then let the back end settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // hold write enable high across consecutive writes
    task automatic write_reg(int idx, logic [RawW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= CfgIdxW'(idx);
        cfg_data <= data;
        @(posedge clk);
        cfg_shadow[idx] = (idx >= REG_WIDTH) ? (data & 32'h1FFF) : data;
        @(negedge clk);
    endtask

    task automatic apply_profile(profile_t prof);
        logic [RawW-1:0] v [8];
        case (prof)
            PROF_EXTREME:
            begin
                v[REG_X_MIN] = 32'h8000_0000; v[REG_X_MAX] = 32'h7FFF_FFFF;
                v[REG_Y_MIN] = 32'h8000_0000; v[REG_Y_MAX] = 32'h7FFF_FFFF;
                v[REG_P_MIN] = 32'h8000_0000; v[REG_P_MAX] = 32'h7FFF_FFFF;
                v[REG_WIDTH] = 32'd8191;      v[REG_HEIGHT] = 32'd8191;
            end
            PROF_INVERTED:
            begin
                v[REG_X_MIN] = 32'h7FFF_FFFF; v[REG_X_MAX] = 32'h8000_0000;
                v[REG_Y_MIN] = 32'd100;       v[REG_Y_MAX] = -32'sd100;
                v[REG_P_MIN] = 32'h7FFF_FFFF; v[REG_P_MAX] = 32'h7FFF_FFFF;
                v[REG_WIDTH] = 32'd8191;      v[REG_HEIGHT] = 32'd1;
            end
            PROF_EQUAL:
            begin
                v[REG_X_MIN] = $urandom; v[REG_X_MAX] = v[REG_X_MIN];
                v[REG_Y_MIN] = $urandom; v[REG_Y_MAX] = v[REG_Y_MIN];
                v[REG_P_MIN] = $urandom; v[REG_P_MAX] = v[REG_P_MIN];
                v[REG_WIDTH] = 32'd0;    v[REG_HEIGHT] = 32'd8191;
            end
            PROF_TABLET:
            begin
                v[REG_X_MIN] = 32'd0;    v[REG_X_MAX] = 32'd20966;
                v[REG_Y_MIN] = 32'd0;    v[REG_Y_MAX] = 32'd15725;
                v[REG_P_MIN] = 32'd0;    v[REG_P_MAX] = 32'd4095;
                v[REG_WIDTH] = 32'd1404; v[REG_HEIGHT] = 32'd1872;
            end
            PROF_NARROW:
            begin
                v[REG_X_MIN] = $urandom; v[REG_X_MAX] = v[REG_X_MIN] + $urandom_range(1, 20);
                v[REG_Y_MIN] = $urandom; v[REG_Y_MAX] = v[REG_Y_MIN] + $urandom_range(1, 20);
                v[REG_P_MIN] = $urandom; v[REG_P_MAX] = v[REG_P_MIN] + $urandom_range(1, 20);
                v[REG_WIDTH] = $urandom_range(0, 8191);
                v[REG_HEIGHT] = $urandom_range(0, 8191);
            end
            PROF_NEGATIVE:
            begin
                v[REG_X_MIN] = -32'sd1000;    v[REG_X_MAX] = -32'sd1;
                v[REG_Y_MIN] = 32'h8000_0000; v[REG_Y_MAX] = 32'h8000_0003;
                v[REG_P_MIN] = -32'sd65536;   v[REG_P_MAX] = -32'sd1;
                v[REG_WIDTH] = 32'd1;         v[REG_HEIGHT] = 32'd0;
            end
            default:
            begin
                v[REG_X_MIN] = $urandom; v[REG_X_MAX] = $urandom;
                v[REG_Y_MIN] = $urandom; v[REG_Y_MAX] = $urandom;
                v[REG_P_MIN] = $urandom; v[REG_P_MAX] = $urandom;
                v[REG_WIDTH] = $urandom_range(0, 8191);
                v[REG_HEIGHT] = $urandom_range(0, 8191);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(i, v[i]);
        cfg_write <= 1'b0;
    endtask

    // output side: random stalls, one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYC) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                n = stall_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_exp_t got;
        frame_exp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{screen_x, screen_y, pressure_level, pen_touching, eraser_touching};
            frames_seen++;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame %0d: none expected, got x=%0d y=%0d p=%0d pen=%0b er=%0b",
                             frames_seen, got.x, got.y, got.p, got.pen, got.er);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.p !== want.p ||
                    got.pen !== want.pen || got.er !== want.er)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"frame %0d: expected x=%0d y=%0d p=%0d pen=%0b er=%0b,",
                                  " got x=%0d y=%0d p=%0d pen=%0b er=%0b"},
                                 frames_seen, want.x, want.y, want.p, want.pen, want.er,
                                 got.x, got.y, got.p, got.pen, got.er);
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("pen_event_frame_assembler_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        event_type = '0;
        event_code = '0;
        event_value = '0;
        cfg_shadow = '{32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0};
        raw_x = '0;
        raw_y = '0;
        raw_p = '0;
        pen_down = 1'b0;
        eraser_down = 1'b0;
        rubber_near = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (int i = 0; i < ROWS; i++)
            send_word(directed_rows[i].etype, directed_rows[i].ecode, directed_rows[i].evalue,
                      directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            apply_profile(plan[ph]);
            calm = (ph == CALM_PHASE);
            if (ph == PRESS_PHASE)
            begin
                calm = 1'b1;
                hold_req = 1'b1;
                repeat (FRAMES_PER) send_frame(1'b1);
                calm = 1'b0;
            end
            for (int k = 0; k < FRAMES_PER; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    send_noise();
                send_frame(1'b0);
            end
            calm = 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_frames.size() == 0)
            $display("pen_event_frame_assembler_core: match");
        else
            $display("pen_event_frame_assembler_core: mismatch");
        $finish;
    end

endmodule
